FILE: rtl/core/ltcl_pkg.sv
// ltcl_pkg: shared constants of the tile-tag cache lookup unit
// depends on nothing; used by lru_tile_cache_lookup_unit
`timescale 1ns / 1ps

package ltcl_pkg;

	// geometry and payload widths fixed by the field definitions
	localparam int unsigned COORD_W = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned SLOTF_W = 2;
	localparam int unsigned STAMP_W = 32;

	// reciprocal scaling for the divide by the tile edge
	localparam int unsigned DIV_SHIFT = 33;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_PLANE_VALID  = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_SERVED      = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECTED    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FILL_FAILED = 2'd2;

endpackage

FILE: rtl/core/lru_tile_cache_lookup_unit.sv
// lru_tile_cache_lookup_unit: fully associative tile-tag cache with lru victim choice
// depends on ltcl_pkg for widths, register indexes and status codes
`timescale 1ns / 1ps

// A request beat names a pixel; the unit rejects it when the plane is not
// valid or the pixel lies outside the configured width and height, else it
// aligns the pixel to its tile origin, looks the tile up among SLOTS tag
// entries and returns one result beat with status, hit, slot, tile origin
// and the row-major index of the pixel inside its tile (clipped at the
// right plane edge). A hit refreshes the slot's use stamp; a miss takes the
// first invalid slot, else the one with the lowest stamp, and the fill_ok
// bit of the request decides whether the fill lands or the victim is
// dropped. A served request runs from acceptance to its result beat in
// these steps: four products on the one shared multiplier (two reciprocal
// divides and two origin products, the local index product overlapping the
// first tag compare), one tag entry per cycle in the slot walk and one
// finish step that loads the output register. A rejected request goes
// straight to the finish step. The finish step stalls for as long as an
// earlier result beat still waits unaccepted. The unit takes one request
// at a time; in_ready is high only while the sequencer is idle, so a new
// request is not taken until the previous one has left the finish step,
// and a new request may be taken while the previous result beat still
// waits in the output register. No clearing pass is needed after reset.
// Configuration writes must be made only while the unit is idle; the unit
// does not enforce this. Configuration writes do not flush the cache.
module lru_tile_cache_lookup_unit #(
	parameter int unsigned SLOTS     = 4,
	parameter int unsigned TILE_EDGE = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [ltcl_pkg::CIDX_W-1:0]   cfg_idx,
	input  logic [ltcl_pkg::CFG_W-1:0]    cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ltcl_pkg::COORD_W-1:0]  pix_x,
	input  logic [ltcl_pkg::COORD_W-1:0]  pix_y,
	input  logic                          fill_ok,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ltcl_pkg::STAT_W-1:0]   status,
	output logic                          hit,
	output logic [ltcl_pkg::SLOTF_W-1:0]  slot,
	output logic [ltcl_pkg::COORD_W-1:0]  tile_x,
	output logic [ltcl_pkg::COORD_W-1:0]  tile_y,
	output logic [ltcl_pkg::COORD_W-1:0]  local_index
);

	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned TW_W   = $clog2(TILE_EDGE + 1);
	// x / TILE_EDGE == (x * RECIP) >> DIV_SHIFT exactly for 16-bit x
	localparam logic [63:0] RECIP  =
		((64'd1 << ltcl_pkg::DIV_SHIFT) + 64'(TILE_EDGE) - 64'd1) / 64'(TILE_EDGE);
	localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
	localparam int unsigned PROD_W  = ltcl_pkg::COORD_W + RECIP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVX,
		S_DIVY,
		S_ORGX,
		S_ORGY,
		S_SCAN,
		S_FIN
	} state_t;

	// configuration registers
	logic [ltcl_pkg::CFG_W-1:0] img_w_q;
	logic [ltcl_pkg::CFG_W-1:0] img_h_q;
	logic                       plane_ok_q;

	// sequencer and request context
	state_t                        state_q;
	logic [SLOT_W-1:0]             scan_idx_q;
	logic [ltcl_pkg::COORD_W-1:0]  x_q, y_q;
	logic                          fill_ok_q;
	logic                          rej_q;
	logic [ltcl_pkg::COORD_W-1:0]  qx_q, qy_q;
	logic [ltcl_pkg::COORD_W-1:0]  tx_q, ty_q;
	logic [TW_W-1:0]               tw_q;
	logic [ltcl_pkg::COORD_W-1:0]  li_q;

	// slot walk trackers
	logic                          found_q;
	logic [SLOT_W-1:0]             hit_slot_q;
	logic                          inv_found_q;
	logic [SLOT_W-1:0]             victim_q;
	logic [ltcl_pkg::STAMP_W-1:0]  min_use_q;

	// tag store
	logic [SLOTS-1:0]              slot_valid_q;
	logic [ltcl_pkg::COORD_W-1:0]  slot_tx_q  [SLOTS];
	logic [ltcl_pkg::COORD_W-1:0]  slot_ty_q  [SLOTS];
	logic [ltcl_pkg::STAMP_W-1:0]  slot_use_q [SLOTS];
	logic [ltcl_pkg::STAMP_W-1:0]  use_clock_q;

	// output register
	logic                          out_valid_q;
	logic [ltcl_pkg::STAT_W-1:0]   status_q;
	logic                          hit_q;
	logic [ltcl_pkg::SLOTF_W-1:0]  slot_q;
	logic [ltcl_pkg::COORD_W-1:0]  tile_x_q, tile_y_q, local_index_q;

	// shared multiplier
	logic [ltcl_pkg::COORD_W-1:0]  mul_a;
	logic [RECIP_W-1:0]            mul_b;
	logic [PROD_W-1:0]             prod;

	logic                          req_rej;
	logic                          tag_hit;
	logic [ltcl_pkg::COORD_W-1:0]  tw_full;
	logic                          out_free;
	logic [ltcl_pkg::STAMP_W-1:0]  use_next;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign tile_x      = tile_x_q;
	assign tile_y      = tile_y_q;
	assign local_index = local_index_q;

	assign req_rej  = !plane_ok_q || (pix_x >= img_w_q) || (pix_y >= img_h_q);
	assign tag_hit  = slot_valid_q[scan_idx_q] && (slot_tx_q[scan_idx_q] == tx_q)
		&& (slot_ty_q[scan_idx_q] == ty_q);
	// tile origin never exceeds the pixel, so this stays non-negative
	assign tw_full  = img_w_q - tx_q;
	assign out_free = !out_valid_q || out_ready;
	assign use_next = use_clock_q + 1'b1;

	// operand selection for the one multiplier
	always_comb begin
		mul_a = x_q;
		mul_b = RECIP_W'(RECIP);
		case (state_q)
			S_DIVY: begin
				mul_a = y_q;
			end
			S_ORGX: begin
				mul_a = qx_q;
				mul_b = RECIP_W'(TILE_EDGE);
			end
			S_ORGY: begin
				mul_a = qy_q;
				mul_b = RECIP_W'(TILE_EDGE);
			end
			S_SCAN: begin
				// row offset times clipped width
				mul_a = y_q - ty_q;
				mul_b = RECIP_W'(tw_q);
			end
			default: begin
				mul_a = x_q;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q    <= '0;
			img_h_q    <= '0;
			plane_ok_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				ltcl_pkg::CFG_IMAGE_WIDTH:  img_w_q    <= cfg_wdata;
				ltcl_pkg::CFG_IMAGE_HEIGHT: img_h_q    <= cfg_wdata;
				ltcl_pkg::CFG_PLANE_VALID:  plane_ok_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer, tag store and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			inv_found_q  <= 1'b0;
			slot_valid_q <= '0;
			use_clock_q  <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_use_q[i] <= '0;
			end
		end else begin
			// the finish step reloads the register itself when the beat leaves
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q         <= pix_x;
						y_q         <= pix_y;
						fill_ok_q   <= fill_ok;
						rej_q       <= req_rej;
						found_q     <= 1'b0;
						inv_found_q <= 1'b0;
						scan_idx_q  <= '0;
						state_q     <= req_rej ? S_FIN : S_DIVX;
					end
				end
				S_DIVX: begin
					qx_q    <= ltcl_pkg::COORD_W'(prod >> ltcl_pkg::DIV_SHIFT);
					state_q <= S_DIVY;
				end
				S_DIVY: begin
					qy_q    <= ltcl_pkg::COORD_W'(prod >> ltcl_pkg::DIV_SHIFT);
					state_q <= S_ORGX;
				end
				S_ORGX: begin
					tx_q    <= prod[ltcl_pkg::COORD_W-1:0];
					state_q <= S_ORGY;
				end
				S_ORGY: begin
					ty_q    <= prod[ltcl_pkg::COORD_W-1:0];
					// clip the tile width at the right plane edge
					if (tw_full > ltcl_pkg::COORD_W'(TILE_EDGE)) begin
						tw_q <= TW_W'(TILE_EDGE);
					end else begin
						tw_q <= TW_W'(tw_full);
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_idx_q == '0) begin
						li_q <= prod[ltcl_pkg::COORD_W-1:0] + (x_q - tx_q);
					end
					// first matching valid entry wins
					if (!found_q && tag_hit) begin
						found_q    <= 1'b1;
						hit_slot_q <= scan_idx_q;
					end
					// first free entry, else lowest stamp with earliest slot on ties
					if (!inv_found_q) begin
						if (!slot_valid_q[scan_idx_q]) begin
							inv_found_q <= 1'b1;
							victim_q    <= scan_idx_q;
						end else if (scan_idx_q == '0
							|| slot_use_q[scan_idx_q] < min_use_q) begin
							victim_q  <= scan_idx_q;
							min_use_q <= slot_use_q[scan_idx_q];
						end
					end
					if (scan_idx_q == SLOT_W'(SLOTS - 1)) begin
						scan_idx_q <= '0;
						state_q    <= S_FIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (rej_q) begin
							status_q      <= ltcl_pkg::ST_REJECTED;
							hit_q         <= 1'b0;
							slot_q        <= '0;
							tile_x_q      <= '0;
							tile_y_q      <= '0;
							local_index_q <= '0;
						end else if (found_q) begin
							use_clock_q            <= use_next;
							slot_use_q[hit_slot_q] <= use_next;
							status_q               <= ltcl_pkg::ST_SERVED;
							hit_q                  <= 1'b1;
							slot_q                 <= ltcl_pkg::SLOTF_W'(hit_slot_q);
							tile_x_q               <= tx_q;
							tile_y_q               <= ty_q;
							local_index_q          <= li_q;
						end else if (!fill_ok_q) begin
							slot_valid_q[victim_q] <= 1'b0;
							status_q               <= ltcl_pkg::ST_FILL_FAILED;
							hit_q                  <= 1'b0;
							slot_q                 <= ltcl_pkg::SLOTF_W'(victim_q);
							tile_x_q               <= tx_q;
							tile_y_q               <= ty_q;
							local_index_q          <= '0;
						end else begin
							slot_valid_q[victim_q] <= 1'b1;
							slot_tx_q[victim_q]    <= tx_q;
							slot_ty_q[victim_q]    <= ty_q;
							slot_use_q[victim_q]   <= use_next;
							use_clock_q            <= use_next;
							status_q               <= ltcl_pkg::ST_SERVED;
							hit_q                  <= 1'b0;
							slot_q                 <= ltcl_pkg::SLOTF_W'(victim_q);
							tile_x_q               <= tx_q;
							tile_y_q               <= ty_q;
							local_index_q          <= li_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result beat only appears out of the finish step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result beat raised outside the finish step");

	// the use clock only ever steps by one, and only when a result is committed
	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		use_clock_q != $past(use_clock_q) |->
			use_clock_q == $past(use_clock_q) + 1'b1 && $past(state_q) == S_FIN)
		else $error("use clock moved unexpectedly");

	// slot walk always starts from the first entry
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_SCAN |-> scan_idx_q == '0)
		else $error("slot walk index left non-zero");

	// an accepted request starts the sequencer at the first divide or the finish step
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DIVX || state_q == S_FIN)
		else $error("accepted request did not start the sequencer");

endmodule

FILE: tb/sv/tb_lru_tile_cache_lookup_unit.sv
// tb_lru_tile_cache_lookup_unit: self-checking bench for the tile-tag cache lookup unit
// depends on ltcl_pkg and lru_tile_cache_lookup_unit; has its own model of the lru tag cache
`timescale 1ns / 1ps

module tb_lru_tile_cache_lookup_unit;

	localparam int unsigned SLOT_COUNT = 4;
	localparam int unsigned TILE_EDGE  = 256;
	localparam int          POOL       = 6;   // tiles in play per random phase, more than the slots
	localparam logic [ltcl_pkg::CIDX_W-1:0] CFG_SPARE_IDX = 2'd3;   // no register behind it

	// one result beat as the unit returns it
	typedef struct packed {
		logic [ltcl_pkg::STAT_W-1:0]  status;
		logic                         hit;
		logic [ltcl_pkg::SLOTF_W-1:0] slot;
		logic [ltcl_pkg::COORD_W-1:0] tile_x;
		logic [ltcl_pkg::COORD_W-1:0] tile_y;
		logic [ltcl_pkg::COORD_W-1:0] local_index;
	} tile_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [ltcl_pkg::CIDX_W-1:0]   cfg_idx;
	logic [ltcl_pkg::CFG_W-1:0]    cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic [ltcl_pkg::COORD_W-1:0]  pix_x;
	logic [ltcl_pkg::COORD_W-1:0]  pix_y;
	logic                          fill_ok;
	logic                          out_valid;
	logic                          out_ready;
	logic [ltcl_pkg::STAT_W-1:0]   status;
	logic                          hit;
	logic [ltcl_pkg::SLOTF_W-1:0]  slot;
	logic [ltcl_pkg::COORD_W-1:0]  tile_x;
	logic [ltcl_pkg::COORD_W-1:0]  tile_y;
	logic [ltcl_pkg::COORD_W-1:0]  local_index;

	lru_tile_cache_lookup_unit #(
		.SLOTS     (SLOT_COUNT),
		.TILE_EDGE (TILE_EDGE)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.fill_ok     (fill_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.hit         (hit),
		.slot        (slot),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.local_index (local_index)
	);

	// model of the unit: geometry registers and the tag store
	logic [ltcl_pkg::CFG_W-1:0]   geo_width;
	logic [ltcl_pkg::CFG_W-1:0]   geo_height;
	logic                         geo_plane_ok;
	logic                         tag_valid [SLOT_COUNT];
	logic [ltcl_pkg::COORD_W-1:0] tag_x     [SLOT_COUNT];
	logic [ltcl_pkg::COORD_W-1:0] tag_y     [SLOT_COUNT];
	logic [ltcl_pkg::STAMP_W-1:0] tag_stamp [SLOT_COUNT];
	logic [ltcl_pkg::STAMP_W-1:0] use_count;

	tile_result_t pending_results [$];

	// run bookkeeping
	int  mismatches;
	int  beats_checked;
	int  n_hits;
	int  n_fills;
	int  n_fill_fails;
	int  n_rejects;
	int  n_settings;
	bit  no_idle;   // set for the stretch where neither side pauses

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// fixed guard on the whole run, well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("[lru_tile_cache_lookup_unit] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result beat %0d on %s: got 0x%0h, expected 0x%0h",
			beats_checked, what, got, want);
		mismatches++;
	endtask

	// works out the result beat of one lookup and moves the model state on
	function automatic tile_result_t predict_lookup(input logic [ltcl_pkg::COORD_W-1:0] x,
			input logic [ltcl_pkg::COORD_W-1:0] y, input logic fill);
		tile_result_t r;
		int unsigned  ox, oy, tw, idx;
		int           found, victim;
		r = '0;
		r.status = ltcl_pkg::ST_REJECTED;
		if (!geo_plane_ok || x >= geo_width || y >= geo_height)
			return r;
		ox = (int'(x) / TILE_EDGE) * TILE_EDGE;
		oy = (int'(y) / TILE_EDGE) * TILE_EDGE;
		// right-edge tiles are narrower than the tile edge
		tw = int'(geo_width) - ox;
		if (tw > TILE_EDGE)
			tw = TILE_EDGE;
		idx = (int'(y) - oy) * tw + (int'(x) - ox);
		r.tile_x = ox[ltcl_pkg::COORD_W-1:0];
		r.tile_y = oy[ltcl_pkg::COORD_W-1:0];
		found = -1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (tag_valid[i] && tag_x[i] == r.tile_x && tag_y[i] == r.tile_y) begin
				found = i;
				break;
			end
		end
		if (found >= 0) begin
			use_count = use_count + 1;
			tag_stamp[found] = use_count;
			r.status = ltcl_pkg::ST_SERVED;
			r.hit = 1'b1;
			r.slot = found[ltcl_pkg::SLOTF_W-1:0];
			r.local_index = idx[ltcl_pkg::COORD_W-1:0];
			return r;
		end
		// victim: first empty slot, else the oldest stamp, lowest slot on ties
		victim = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!tag_valid[i]) begin
				victim = i;
				break;
			end
			if (tag_stamp[i] < tag_stamp[victim])
				victim = i;
		end
		r.slot = victim[ltcl_pkg::SLOTF_W-1:0];
		if (!fill) begin
			// failed fill drops the victim and leaves the use clock alone
			tag_valid[victim] = 1'b0;
			r.status = ltcl_pkg::ST_FILL_FAILED;
			return r;
		end
		tag_valid[victim] = 1'b1;
		tag_x[victim] = r.tile_x;
		tag_y[victim] = r.tile_y;
		use_count = use_count + 1;
		tag_stamp[victim] = use_count;
		r.status = ltcl_pkg::ST_SERVED;
		r.local_index = idx[ltcl_pkg::COORD_W-1:0];
		return r;
	endfunction

	// result side: random back-pressure, none during the steady stretch
	always @(posedge clk) begin
		out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 6);
	end

	// compare every accepted result beat with the oldest prediction
	always @(posedge clk) begin
		tile_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", 32'(status), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				if (slot !== want.slot)
					report_mismatch("slot", 32'(slot), 32'(want.slot));
				if (tile_x !== want.tile_x)
					report_mismatch("tile_x", 32'(tile_x), 32'(want.tile_x));
				if (tile_y !== want.tile_y)
					report_mismatch("tile_y", 32'(tile_y), 32'(want.tile_y));
				if (local_index !== want.local_index)
					report_mismatch("local_index", 32'(local_index),
						32'(want.local_index));
			end
			beats_checked++;
		end
	end

	// one lookup beat; valid is left high so back-to-back beats need no toggle
	task automatic send_lookup(input logic [ltcl_pkg::COORD_W-1:0] x,
			input logic [ltcl_pkg::COORD_W-1:0] y, input logic fill);
		tile_result_t r;
		if (!no_idle && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pix_x    <= x;
		pix_y    <= y;
		fill_ok  <= fill;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_lookup(x, y, fill);
		case (r.status)
			ltcl_pkg::ST_REJECTED:    n_rejects++;
			ltcl_pkg::ST_FILL_FAILED: n_fill_fails++;
			default: begin
				if (r.hit)
					n_hits++;
				else
					n_fills++;
			end
		endcase
		pending_results.push_back(r);
	endtask

	// lower valid, let every result come back, then allow the unit to settle
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SLOT_COUNT + 8) @(posedge clk);
	endtask

	// register write; the model follows the same write, spare index ignored
	task automatic write_reg(input logic [ltcl_pkg::CIDX_W-1:0] idx,
			input logic [ltcl_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			ltcl_pkg::CFG_IMAGE_WIDTH:  geo_width    = val;
			ltcl_pkg::CFG_IMAGE_HEIGHT: geo_height   = val;
			ltcl_pkg::CFG_PLANE_VALID:  geo_plane_ok = val[0];
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_geometry(input int w, input int h, input logic ok);
		write_reg(ltcl_pkg::CFG_IMAGE_WIDTH, w[ltcl_pkg::CFG_W-1:0]);
		write_reg(ltcl_pkg::CFG_IMAGE_HEIGHT, h[ltcl_pkg::CFG_W-1:0]);
		write_reg(ltcl_pkg::CFG_PLANE_VALID, {{(ltcl_pkg::CFG_W-1){1'b0}}, ok});
		n_settings++;
	endtask

	// registers at reset: zero-sized, unusable plane, so every lookup is turned away
	task automatic test_reset_defaults;
		send_lookup(16'd0, 16'd0, 1'b1);
		send_lookup(16'hFFFF, 16'hFFFF, 1'b0);
		drain();
		// a write to the spare index must not touch anything
		write_reg(CFG_SPARE_IDX, 16'hFFFF);
		write_reg(ltcl_pkg::CFG_PLANE_VALID, 16'd1);
		// usable plane but still zero width and height
		send_lookup(16'd0, 16'd0, 1'b1);
		drain();
	endtask

	// range checks at the plane borders and a clipped right-edge tile
	task automatic test_plane_borders;
		apply_geometry(1000, 600, 1'b1);
		send_lookup(16'd0, 16'd0, 1'b1);
		send_lookup(16'd999, 16'd599, 1'b1);
		send_lookup(16'd1000, 16'd5, 1'b1);
		send_lookup(16'd5, 16'd600, 1'b1);
		send_lookup(16'd255, 16'd255, 1'b1);
		drain();
	endtask

	// fill the remaining slots, refresh one, evict the oldest, then two failed fills and a fill
	task automatic test_lru_victims;
		send_lookup(16'd256, 16'd0, 1'b1);
		send_lookup(16'd512, 16'd256, 1'b1);
		send_lookup(16'd10, 16'd10, 1'b1);
		send_lookup(16'd768, 16'd0, 1'b1);
		send_lookup(16'd0, 16'd512, 1'b0);
		send_lookup(16'd300, 16'd300, 1'b0);
		send_lookup(16'd0, 16'd512, 1'b1);
		drain();
	endtask

	// geometry changes keep the tags but alter the clipped width
	task automatic test_geometry_change;
		apply_geometry(65535, 65535, 1'b1);
		send_lookup(16'd65534, 16'd65534, 1'b1);
		send_lookup(16'd999, 16'd599, 1'b1);
		send_lookup(16'hFFFF, 16'd0, 1'b1);
		drain();
		write_reg(ltcl_pkg::CFG_PLANE_VALID, 16'd0);
		send_lookup(16'd0, 16'd0, 1'b1);
		drain();
		apply_geometry(1, 1, 1'b1);
		send_lookup(16'd0, 16'd0, 1'b1);
		send_lookup(16'd1, 16'd0, 1'b1);
		send_lookup(16'd0, 16'd1, 1'b1);
		drain();
	endtask

	// mostly lookups into a small pool of tiles so hits and evictions dominate,
	// with some fully random coordinates as noise
	task automatic run_random(input int n_items, input int w, input int h);
		int pool_x [POOL];
		int pool_y [POOL];
		int k, px, py, span_x, span_y;
		apply_geometry(w, h, 1'b1);
		for (int i = 0; i < POOL; i++) begin
			pool_x[i] = $urandom_range(0, (w - 1) / TILE_EDGE) * TILE_EDGE;
			pool_y[i] = $urandom_range(0, (h - 1) / TILE_EDGE) * TILE_EDGE;
		end
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 99) < 85) begin
				k = $urandom_range(0, POOL - 1);
				span_x = w - 1 - pool_x[k];
				span_y = h - 1 - pool_y[k];
				if (span_x > TILE_EDGE - 1)
					span_x = TILE_EDGE - 1;
				if (span_y > TILE_EDGE - 1)
					span_y = TILE_EDGE - 1;
				px = pool_x[k] + $urandom_range(0, span_x);
				py = pool_y[k] + $urandom_range(0, span_y);
			end else begin
				px = $urandom_range(0, 65535);
				py = $urandom_range(0, 65535);
			end
			send_lookup(px[ltcl_pkg::COORD_W-1:0], py[ltcl_pkg::COORD_W-1:0],
				$urandom_range(0, 99) < 85);
		end
		drain();
	endtask

	task automatic test_random_mix;
		run_random(250, 65535, 65535);
		run_random(200, $urandom_range(1, 1500), $urandom_range(1, 1500));
		// long stretch with no pauses on either side
		no_idle = 1'b1;
		run_random(250, 4000, 3000);
		no_idle = 1'b0;
		run_random(150, $urandom_range(1, 300), $urandom_range(1, 300));
		run_random(150, 65535, $urandom_range(256, 65535));
	endtask

	initial begin
		mismatches    = 0;
		beats_checked = 0;
		n_hits        = 0;
		n_fills       = 0;
		n_fill_fails  = 0;
		n_rejects     = 0;
		n_settings    = 0;
		no_idle       = 1'b0;
		geo_width     = '0;
		geo_height    = '0;
		geo_plane_ok  = 1'b0;
		use_count     = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			tag_valid[i] = 1'b0;
			tag_x[i]     = '0;
			tag_y[i]     = '0;
			tag_stamp[i] = '0;
		end
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_idx   <= '0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		pix_x     <= '0;
		pix_y     <= '0;
		fill_ok   <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_plane_borders();
		test_lru_victims();
		test_geometry_change();
		test_random_mix();

		$display("checked %0d result beats over %0d plane settings", beats_checked, n_settings);
		$display("%0d hits, %0d fills, %0d failed fills, %0d rejected", n_hits, n_fills,
			n_fill_fails, n_rejects);
		if (mismatches == 0) begin
			$display("[lru_tile_cache_lookup_unit] OK");
		end else begin
			$display("[lru_tile_cache_lookup_unit] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ltcl_pkg.sv
rtl/core/lru_tile_cache_lookup_unit.sv
tb/sv/tb_lru_tile_cache_lookup_unit.sv
